[rtl/aht_pkg.sv]
// ----------------------------------------------------------------------------
// Address hook table package
// Shared types and codes for the address hook table cells and core.
// ----------------------------------------------------------------------------
`default_nettype none

package aht_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned PAGE_W   = 52;
  localparam int unsigned ID_W     = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_W     = 184;
  localparam int unsigned OUT_W    = 72;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PAGE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // Probe that walks the row of cells, gathering search results.
  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [PAGE_W-1:0] page_number;
    logic [ID_W-1:0]   new_hook_id;
    logic              hit;
    logic              page_hit;
    logic [ID_W-1:0]   found_id;
    logic [ADDR_W-1:0] last_address;
    logic [ID_W-1:0]   last_id;
  } probe_t;

  // Broadcast write to one cell of the row.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] address;
    logic [ID_W-1:0]   id;
  } write_t;

endpackage : aht_pkg

`default_nettype wire

[rtl/aht_cell.sv]
// ----------------------------------------------------------------------------
// Address hook table cell
// Holds one table entry, compares it against the passing probe and hands the
// probe on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aht_cell #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned PAGE_BITS   = 12,
  parameter int unsigned INDEX       = 0,
  parameter int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  parameter int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire [CNT_W-1:0]      count,
  input  aht_pkg::probe_t      probe_in,
  input  wire [IDX_W-1:0]      slot_in,
  output aht_pkg::probe_t      probe_out,
  output logic [IDX_W-1:0]     slot_out,
  input  aht_pkg::write_t      wr,
  input  wire [IDX_W-1:0]      wr_index
);

  import aht_pkg::*;

  logic [ADDR_W-1:0] entry_address;
  logic [ID_W-1:0]   entry_id;
  logic              live;
  logic              addr_match;
  logic              page_match;
  logic              is_last;
  logic [ADDR_W-1:0] entry_page;
  probe_t            probe_next;
  logic [IDX_W-1:0]  slot_next;

  // Entry comparisons against the passing probe.
  assign live       = CNT_W'(INDEX) < count;
  assign entry_page = entry_address >> PAGE_BITS;
  assign addr_match = live && (entry_address == probe_in.address);
  assign page_match = live && (entry_page == ADDR_W'(probe_in.page_number));
  assign is_last    = live && (CNT_W'(INDEX + 1) == count);

  // Fold this entry into the probe; the first address match wins.
  always_comb begin
    probe_next = probe_in;
    slot_next  = slot_in;
    if (addr_match && !probe_in.hit) begin
      probe_next.hit      = 1'b1;
      probe_next.found_id = entry_id;
      slot_next           = IDX_W'(INDEX);
    end
    if (page_match) begin
      probe_next.page_hit = 1'b1;
    end
    if (is_last) begin
      probe_next.last_address = entry_address;
      probe_next.last_id      = entry_id;
    end
  end

  // Probe stage register towards the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out <= probe_next;
      slot_out  <= slot_next;
    end
  end

  // Entry storage, written by the core's broadcast.
  always_ff @(posedge clk) begin
    if (wr.en && (wr_index == IDX_W'(INDEX))) begin
      entry_address <= wr.address;
      entry_id      <= wr.id;
    end
  end

endmodule : aht_cell

`default_nettype wire

[rtl/address_hook_table_core.sv]
// ----------------------------------------------------------------------------
// Address hook table core
// Small associative table of (address, hook id) pairs held in a row of cells.
//
//   Channel | Direction | Beat contents
//   s_axis  | in        | mode, address, page_number, new_hook_id
//   m_axis  | out       | hit, found_id, status
//
// Each beat launches a probe into cell 0; it moves one cell per cycle through
// the cell registers and, from the last cell, into the result register. The
// next beat is taken only after the item is committed. One item is in the row
// at a time; a new beat is taken while an earlier result still waits on the
// output. Reset empties the table at once; there is no clearing pass.
// A stalled output holds the finished item before its table update.
// ----------------------------------------------------------------------------
`default_nettype none

module address_hook_table_core #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned PAGE_BITS   = 12
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      s_tvalid,
  output logic                     s_tready,
  // mode [2:0], address [66:3], page_number [118:67], new_hook_id [182:119]
  input  wire [aht_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  wire                      m_tready,
  // hit [0], found_id [64:1], status [66:65]
  output logic [aht_pkg::OUT_W-1:0] m_tdata
);

  import aht_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  probe_t            result;
  logic [IDX_W-1:0]  result_slot;
  probe_t            head;
  probe_t            probe_chain [0:TABLE_DEPTH];
  logic [IDX_W-1:0]  slot_chain  [0:TABLE_DEPTH];
  write_t            wr;
  logic [IDX_W-1:0]  wr_index;
  logic              in_accept;
  logic              commit;
  logic              out_hit;
  logic [ID_W-1:0]   out_id;
  logic [STATUS_W-1:0] out_status;

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign commit    = (state == S_DONE) && (!m_tvalid || m_tready);

  // Probe entering the first cell.
  always_comb begin
    head              = '0;
    head.valid        = in_accept;
    head.mode         = s_tdata[2:0];
    head.address      = s_tdata[66:3];
    head.page_number  = s_tdata[118:67];
    head.new_hook_id  = s_tdata[182:119];
  end

  assign probe_chain[0] = head;
  assign slot_chain[0]  = '0;

  // Row of cells, one per table slot.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    aht_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .PAGE_BITS   (PAGE_BITS),
      .INDEX       (k),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .count     (count),
      .probe_in  (probe_chain[k]),
      .slot_in   (slot_chain[k]),
      .probe_out (probe_chain[k+1]),
      .slot_out  (slot_chain[k+1]),
      .wr        (wr),
      .wr_index  (wr_index)
    );
  end

  // Sequencing of one item through the row.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_WALK;
      end
      S_WALK: begin
        if (probe_chain[TABLE_DEPTH].valid) state_next = S_DONE;
      end
      S_DONE: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Table update and result fields for the finished probe.
  always_comb begin
    count_next = count;
    wr         = '0;
    wr_index   = result_slot;
    out_hit    = 1'b0;
    out_id     = '0;
    out_status = ST_OK;
    case (result.mode)
      MODE_LOOKUP: begin
        out_hit = result.hit;
        out_id  = result.hit ? result.found_id : '0;
      end
      MODE_PAGE: begin
        out_hit = result.page_hit;
      end
      MODE_ADD: begin
        if (result.hit) begin
          wr.en = 1'b1;
        end else if (count >= CNT_W'(TABLE_DEPTH)) begin
          out_status = ST_FULL;
        end else begin
          wr.en      = 1'b1;
          wr_index   = count[IDX_W-1:0];
          count_next = count + 1'b1;
        end
        wr.address = result.address;
        wr.id      = result.new_hook_id;
      end
      MODE_REMOVE: begin
        if (result.hit) begin
          // Move the last live entry into the freed slot.
          wr.en      = 1'b1;
          wr.address = result.last_address;
          wr.id      = result.last_id;
          count_next = count - 1'b1;
        end else begin
          out_status = ST_NOT_FOUND;
        end
      end
      MODE_CLEAR: begin
        count_next = '0;
      end
      default: ;
    endcase
    if (!commit) begin
      wr.en      = 1'b0;
      count_next = count;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Probe capture at the end of the row, and the output beat register.
  always_ff @(posedge clk) begin
    if ((state == S_WALK) && probe_chain[TABLE_DEPTH].valid) begin
      result      <= probe_chain[TABLE_DEPTH];
      result_slot <= slot_chain[TABLE_DEPTH];
    end
    if (commit) begin
      m_tdata <= {5'b0, out_status, out_id, out_hit};
    end
  end

`ifndef SYNTHESIS
  // The live count never exceeds the row length.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A probe leaves the row only while an item is being walked.
  assert property (@(posedge clk) disable iff (rst)
    probe_chain[TABLE_DEPTH].valid |-> state == S_WALK)
    else $error("probe left the row outside a walk");

  // A new output beat appears only after a finished item was committed.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("output beat without a committed item");

  // A committed clear empties the table.
  assert property (@(posedge clk) disable iff (rst)
    commit && (result.mode == MODE_CLEAR) |=> count == '0)
    else $error("clear left live entries");

  // The count changes only when an item is committed.
  assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(count))
    else $error("entry count changed without a commit");
`endif

endmodule : address_hook_table_core

`default_nettype wire
